@@ rtl/vppc_pkg.sv @@
// ----------------------------------------------------------------------------
// vppc_pkg: shared types and constants of the voice pitch/volume/pan calculator
// Holds the item structs of both channels, the internal pan stage record and
// the fixed constants of the frequency clamp and the pan step scaling.
// ----------------------------------------------------------------------------
package vppc_pkg;

	// Register map: one register, index taken from paddr[2].
	localparam logic REG_OUTPUT_RATE = 1'b0;
	localparam logic [15:0] OUTPUT_RATE_RESET = 16'd32000;

	// Octave search: the top base and the number of halvings.
	localparam logic [22:0] OCT_TOP_BASE = 23'd5644800;
	localparam int unsigned OCT_MAX_HALVINGS = 15;

	// Pan stepping: the ratio 1000/708 is reduced to 250/177.
	localparam logic [7:0] PAN_NUM = 8'd250;
	localparam logic [7:0] PAN_DEN = 8'd177;
	localparam int unsigned PAN_MAX_STEPS = 15;
	// Rounded-up reciprocal of 177 with 32 fraction bits; exact for dividends below 2^24.
	localparam logic [63:0] PAN_RECIP = ((64'd1 << 32) + 64'd176) / 64'd177;
	// Numerator folded into the reciprocal so a step needs one constant multiply.
	localparam logic [63:0] PAN_MAGIC_W = PAN_RECIP * 64'd250;
	localparam logic [32:0] PAN_MAGIC = PAN_MAGIC_W[32:0];

	// Pan output codes.
	localparam logic [7:0] PAN_CENTER = 8'd128;
	localparam logic [7:0] PAN_LEFT_TOP = 8'd127;
	localparam logic [7:0] VOL_MAX = 8'd255;

	// Input item.
	typedef struct packed {
		logic [15:0] resample_rate;
		logic        two_part;
		logic [3:0]  down_shift;
		logic [15:0] level_left;
		logic [15:0] level_right;
	} vppc_voice_t;

	// Result item.
	typedef struct packed {
		logic [17:0] channel_freq;
		logic [7:0]  channel_volume;
		logic [7:0]  channel_pan;
	} vppc_chan_t;

	// Pan record that travels down the step stages.
	typedef struct packed {
		logic [15:0] hi;
		logic [15:0] lo;
		logic [3:0]  n;
		logic        left;
		logic        eq;
		logic [7:0]  vol;
	} vppc_pan_t;

endpackage

@@ rtl/vppc_freq.sv @@
// ----------------------------------------------------------------------------
// vppc_freq: three-stage playback frequency path
// Stage 1 multiplies the resampling rate by the output rate, stage 2 applies
// the two-part doubling, the downsample shift and the floor of 1, stage 3
// runs the octave search and clamps below twice the base found.
// ----------------------------------------------------------------------------
module vppc_freq (
	input  logic                 clk,
	input  logic                 en,
	input  logic [15:0]          rate,
	input  vppc_pkg::vppc_voice_t voice,
	output logic [17:0]          freq
);
	import vppc_pkg::*;

	logic [31:0] prod_s1;
	logic        two_s1;
	logic [3:0]  shift_s1;
	logic [17:0] freq_s2;
	logic [17:0] freq_s3;

	logic [16:0] f_int;
	logic [17:0] f_dbl;
	logic [17:0] f_shr;
	logic [3:0]  sel;
	logic [22:0] base;
	logic [23:0] base_x2;
	logic [17:0] f_clamp;

	// Stage 1: rate product.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= 32'(voice.resample_rate) * 32'(rate);
			two_s1   <= voice.two_part;
			shift_s1 <= voice.down_shift;
		end
	end

	// Drop the fraction bits, double for two-part samples, downsample, floor at 1.
	always_comb begin
		f_int = prod_s1[31:15];
		f_dbl = two_s1 ? {f_int, 1'b0} : {1'b0, f_int};
		f_shr = f_dbl >> shift_s1;
		if (f_shr == 18'd0) begin
			f_shr = 18'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			freq_s2 <= f_shr;
		end
	end

	// Octave search: the first base, halving from the top, that the frequency reaches.
	always_comb begin
		sel = 4'(OCT_MAX_HALVINGS);
		for (int k = OCT_MAX_HALVINGS - 1; k >= 0; k--) begin
			if ({5'd0, freq_s2} >= (OCT_TOP_BASE >> k)) begin
				sel = 4'(k);
			end
		end
		base    = OCT_TOP_BASE >> sel;
		base_x2 = {base, 1'b0};
		if ({6'd0, freq_s2} >= base_x2) begin
			f_clamp = 18'(base_x2 - 24'd1);
		end else begin
			f_clamp = freq_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			freq_s3 <= f_clamp;
		end
	end

	assign freq = freq_s3;

endmodule

@@ rtl/vppc_pan_step.sv @@
// ----------------------------------------------------------------------------
// vppc_pan_step: one registered 3 dB step of the pan ratio search
// While the quieter level scaled by 1000/708 stays below the louder one, the
// quieter level is scaled and the step count grows by one.
// ----------------------------------------------------------------------------
module vppc_pan_step (
	input  logic                clk,
	input  logic                en,
	input  vppc_pkg::vppc_pan_t pan_in,
	output vppc_pkg::vppc_pan_t pan_out
);
	import vppc_pkg::*;

	logic [23:0] lo_scaled;
	logic [23:0] hi_scaled;
	logic [48:0] lo_prod;
	vppc_pan_t   nxt;
	vppc_pan_t   pan_q;

	// Compare lo*250 against hi*177 and scale lo by the folded reciprocal.
	always_comb begin
		lo_scaled = 24'(pan_in.lo) * 24'(PAN_NUM);
		hi_scaled = 24'(pan_in.hi) * 24'(PAN_DEN);
		lo_prod   = 49'(pan_in.lo) * 49'(PAN_MAGIC);
		nxt       = pan_in;
		if (lo_scaled < hi_scaled) begin
			nxt.lo = lo_prod[47:32];
			nxt.n  = pan_in.n + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pan_q <= nxt;
		end
	end

	assign pan_out = pan_q;

endmodule

@@ rtl/voice_pitch_volume_pan_calc.sv @@
// ----------------------------------------------------------------------------
// voice_pitch_volume_pan_calc: voice mixer parameters to channel settings
// Pipelined conversion of a voice's resampling rate and levels into playback
// frequency, volume and pan, with an APB register for the output rate.
// ----------------------------------------------------------------------------
// Usage:
// A voice item is offered on voice/voice_valid and taken at a clock edge where
// voice_valid is high and voice_stall is low. The matching channel item shows
// on chan/chan_valid and is taken when chan_stall is low.
// From acceptance to chan_valid an item passes one input stage, fifteen
// pan step stages (one 3 dB step each) and one output register. The frequency
// path runs in three of these stages alongside and is then delayed to match.
// One item is taken every cycle while the output is not stalled.
// When chan_stall holds a waiting item, the whole pipeline freezes and
// voice_stall rises in the same cycle, so nothing is lost or repeated.
// Reset clears all stage valid bits and sets output_rate to 32000. The
// output_rate register is written over APB at byte address 0; pready is
// always high and reads return the register.
// ----------------------------------------------------------------------------
module voice_pitch_volume_pan_calc (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// Voice items.
	input  logic                  voice_valid,
	output logic                  voice_stall,
	input  vppc_pkg::vppc_voice_t voice,
	// Channel items.
	output logic                  chan_valid,
	input  logic                  chan_stall,
	output vppc_pkg::vppc_chan_t  chan
);
	import vppc_pkg::*;

	localparam int unsigned FREQ_DELAY = PAN_MAX_STEPS - 2;

	logic [15:0] output_rate_q;
	logic        adv;
	logic [16:0] vld_s;
	vppc_pan_t   pan_s [PAN_MAX_STEPS + 1];
	vppc_pan_t   pan_first;
	logic [17:0] freq_s3;
	logic [17:0] freq_dly_s [FREQ_DELAY];
	vppc_chan_t  chan_nxt;
	vppc_chan_t  chan_s17;
	logic [11:0] vol_raw;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_rate_q <= OUTPUT_RATE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_OUTPUT_RATE) begin
			output_rate_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OUTPUT_RATE) ? {16'd0, output_rate_q} : 32'd0;

	// All stages move together unless a finished item is held at the output.
	assign adv         = !(vld_s[16] && chan_stall);
	assign voice_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[15:0], voice_valid};
		end
	end

	// Frequency path, three stages.
	vppc_freq u_freq (
		.clk   (clk),
		.en    (adv),
		.rate  (output_rate_q),
		.voice (voice),
		.freq  (freq_s3)
	);

	// Delay the frequency to line up with the last pan step.
	always_ff @(posedge clk) begin
		if (adv) begin
			freq_dly_s[0] <= freq_s3;
			for (int i = 1; i < FREQ_DELAY; i++) begin
				freq_dly_s[i] <= freq_dly_s[i - 1];
			end
		end
	end

	// Stage 1: order the levels, volume, and the silent-side shortcut.
	always_comb begin
		pan_first.left = voice.level_left > voice.level_right;
		pan_first.eq   = voice.level_left == voice.level_right;
		pan_first.hi   = pan_first.left ? voice.level_left : voice.level_right;
		pan_first.lo   = pan_first.left ? voice.level_right : voice.level_left;
		pan_first.n    = 4'd0;
		// A silent side takes all steps; lo = hi keeps the later steps from counting.
		if (pan_first.lo == 16'd0) begin
			pan_first.n  = 4'(PAN_MAX_STEPS);
			pan_first.lo = pan_first.hi;
		end
		vol_raw = pan_first.hi[15:4];
		pan_first.vol = (vol_raw > 12'(VOL_MAX)) ? VOL_MAX : vol_raw[7:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pan_s[0] <= pan_first;
		end
	end

	// Fifteen pan step stages.
	for (genvar g = 0; g < PAN_MAX_STEPS; g++) begin : g_step
		vppc_pan_step u_step (
			.clk     (clk),
			.en      (adv),
			.pan_in  (pan_s[g]),
			.pan_out (pan_s[g + 1])
		);
	end

	// Output stage: map the step count to a pan position.
	always_comb begin
		chan_nxt.channel_freq   = freq_dly_s[FREQ_DELAY - 1];
		chan_nxt.channel_volume = pan_s[PAN_MAX_STEPS].vol;
		if (pan_s[PAN_MAX_STEPS].eq) begin
			chan_nxt.channel_pan = PAN_CENTER;
		end else if (pan_s[PAN_MAX_STEPS].left) begin
			chan_nxt.channel_pan = PAN_LEFT_TOP - {1'b0, pan_s[PAN_MAX_STEPS].n, 3'b000};
		end else begin
			chan_nxt.channel_pan = PAN_CENTER + {1'b0, pan_s[PAN_MAX_STEPS].n, 3'b000};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chan_s17 <= chan_nxt;
		end
	end

	assign chan_valid = vld_s[16];
	assign chan       = chan_s17;

`ifndef NO_ASSERTIONS
	// The input is held off only while a finished item waits at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		voice_stall |-> (chan_valid && chan_stall))
		else $error("voice_stall without a held output item");

	// A frozen pipeline keeps its valid bits.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_valid && chan_stall) |=> (vld_s == $past(vld_s)))
		else $error("pipeline moved while stalled");

	// Delivered frequency never drops below the floor of 1.
	a_freq_floor: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid |-> (chan.channel_freq != 18'd0))
		else $error("channel_freq is zero");

	// Pan stays within the fifteen steps on either side.
	a_pan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid |-> (chan.channel_pan >= 8'd7 && chan.channel_pan <= 8'd248))
		else $error("channel_pan out of range");
`endif

endmodule
